// ----- hdl/eqbcg_pkg.sv -----
// Shared types, constants and band tables for the EQ biquad coefficient generator.
package eqbcg_pkg;

   localparam int POT_BITS       = 12;
   localparam int COEF_FRAC_BITS = 28;
   localparam int POT_W          = 12;
   localparam int COEF_W         = 32;
   localparam int QB             = 30;
   localparam int VW             = 40;
   localparam int MW             = 36;
   localparam int PW             = 2 * MW;
   localparam int DW             = 64;
   localparam int TAYLOR_TERMS   = 12;
   localparam int CIDX_W         = 3;
   localparam int NUM_COEF       = 5;
   // series terms stay below 2^31, so a 35-bit reciprocal gives the exact quotient
   localparam int RECIP_SH       = 35;

   localparam logic [POT_BITS-1:0] POT_MAX  = {POT_BITS{1'b1}};
   localparam logic [DW-1:0]       POT_HALF = DW'(((1 << POT_BITS) - 1) / 2);
   localparam logic [MW-1:0]       EXP_RATE = MW'(463571610);
   localparam logic [PW-1:0]       QHALF    = PW'(1) << (QB - 1);
   localparam logic signed [VW-1:0] QONE    = VW'(1) << QB;

   localparam logic signed [VW-1:0] COS_400   = VW'(1072270298);
   localparam logic signed [VW-1:0] ALPHA_400 = VW'(39742083);
   localparam logic signed [VW-1:0] COS_1K    = VW'(1064555814);
   localparam logic signed [VW-1:0] ALPHA_1K  = VW'(99116996);
   localparam logic signed [VW-1:0] COS_2K    = VW'(1037154959);
   localparam logic signed [VW-1:0] ALPHA_2K  = VW'(196538072);

   localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   typedef enum logic [1:0] {
      BAND_LOW    = 2'd0,
      BAND_PEAK   = 2'd1,
      BAND_HIGH   = 2'd2,
      BAND_BYPASS = 2'd3
   } band_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [POT_W-1:0] pot_level;
   } req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_b0;
      logic signed [COEF_W-1:0] coef_b1;
      logic signed [COEF_W-1:0] coef_b2;
      logic signed [COEF_W-1:0] coef_a1;
      logic signed [COEF_W-1:0] coef_a2;
   } rsp_type;

   typedef struct packed {
      band_type            band;
      logic [POT_BITS-1:0] cut;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_if_type;

   typedef struct packed {
      logic          start;
      logic [DW-1:0] num;
      logic [DW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic          done;
      logic [DW-1:0] quot;
   } div_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_Y_MUL, S_Y_DIV, S_Y_WAIT, S_T_MUL, S_T_DIV, S_T_WAIT,
      S_A_MUL, S_A_USE, S_T2_MUL, S_T2_USE, S_AMC_MUL, S_AMC_USE,
      S_APC_MUL, S_APC_USE, S_B0_MUL, S_B0_USE, S_B1_MUL, S_B1_USE,
      S_B2_MUL, S_B2_USE, S_AA_MUL, S_AA_USE, S_ADIV_DIV, S_ADIV_WAIT,
      S_C_DIV, S_C_WAIT, S_OUT
   } state_type;

   function automatic logic signed [VW-1:0] band_cos(input band_type b);
      case (b)
         BAND_LOW:  return COS_400;
         BAND_PEAK: return COS_1K;
         default:   return COS_2K;
      endcase
   endfunction

   function automatic logic signed [VW-1:0] band_alpha(input band_type b);
      case (b)
         BAND_LOW:  return ALPHA_400;
         BAND_PEAK: return ALPHA_1K;
         default:   return ALPHA_2K;
      endcase
   endfunction

   // ceil(2^RECIP_SH / k) for the series divisors
   function automatic logic signed [VW-1:0] recip_k(input logic [3:0] k);
      case (k)
         4'd1:    return VW'(64'd1 << RECIP_SH);
         4'd2:    return VW'(((64'd1 << RECIP_SH) + 64'd1) / 64'd2);
         4'd3:    return VW'(((64'd1 << RECIP_SH) + 64'd2) / 64'd3);
         4'd4:    return VW'(((64'd1 << RECIP_SH) + 64'd3) / 64'd4);
         4'd5:    return VW'(((64'd1 << RECIP_SH) + 64'd4) / 64'd5);
         4'd6:    return VW'(((64'd1 << RECIP_SH) + 64'd5) / 64'd6);
         4'd7:    return VW'(((64'd1 << RECIP_SH) + 64'd6) / 64'd7);
         4'd8:    return VW'(((64'd1 << RECIP_SH) + 64'd7) / 64'd8);
         4'd9:    return VW'(((64'd1 << RECIP_SH) + 64'd8) / 64'd9);
         4'd10:   return VW'(((64'd1 << RECIP_SH) + 64'd9) / 64'd10);
         4'd11:   return VW'(((64'd1 << RECIP_SH) + 64'd10) / 64'd11);
         default: return VW'(((64'd1 << RECIP_SH) + 64'd11) / 64'd12);
      endcase
   endfunction

   function automatic logic [MW-1:0] mag(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] n;
      n = -v;
      return v[VW-1] ? n[MW-1:0] : v[MW-1:0];
   endfunction

endpackage

// ----- hdl/eq_biquad_coefficient_generator_unit.sv -----
// Top level of the three-band EQ biquad coefficient generator.
// Each request (band, pot level) yields one set of normalized biquad
// coefficients b0, b1, b2, a1, a2 in signed Q4.28. The pot maps linearly to
// -15..0 dB; the front end queues up to two requests while the core works, and
// a finished result waits in an output register; the core holds before its next
// request only while the previous result is still waiting there.
// One request runs the gain series (shift-add division by the pot range, then
// 12 terms using reciprocal multiplication), followed by 5 (shelf) or 6
// (peaking) divisions on one shared 64-step restoring divider, one quotient
// bit per cycle. Band code 3 returns the pass-through set after the gain series.
module eq_biquad_coefficient_generator_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  eqbcg_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output eqbcg_pkg::rsp_type  rsp_data
);
   eqbcg_pkg::job_if_type  job;
   logic                   job_pop;
   eqbcg_pkg::div_req_type div_req;
   eqbcg_pkg::div_rsp_type div_rsp;

   eqbcg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_out   (job),
      .job_pop   (job_pop)
   );

   eqbcg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   eqbcg_core u_core (
      .clock     (clock),
      .reset     (reset),
      .job_in    (job),
      .job_pop   (job_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule

// ----- hdl/eqbcg_front.sv -----
// Front end: accepts requests, clamps the pot and queues jobs for the core.
module eqbcg_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  eqbcg_pkg::req_type     req_data,
   output eqbcg_pkg::job_if_type  job_out,
   input  logic                   job_pop
);
   localparam int POT_BITS_W = eqbcg_pkg::POT_BITS;

   eqbcg_pkg::job_type  entry_ff [0:1];
   logic                wr_ptr_ff, rd_ptr_ff;
   logic [1:0]          count_ff;
   logic                push;
   logic [16:0]         pot_wide;
   logic [POT_BITS_W-1:0] pot_clamp;
   eqbcg_pkg::job_type  job_new;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   always_comb begin
      pot_wide  = 17'(req_data.pot_level);
      pot_clamp = (pot_wide > 17'(eqbcg_pkg::POT_MAX)) ? eqbcg_pkg::POT_MAX
                                                       : pot_wide[POT_BITS_W-1:0];
      job_new.band = eqbcg_pkg::band_type'(req_data.action);
      job_new.cut  = eqbcg_pkg::POT_MAX - pot_clamp;
   end

   assign job_out.valid = (count_ff != 2'd0);
   assign job_out.job   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (job_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(job_pop);
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_new;
      end
   end
endmodule

// ----- hdl/eqbcg_div.sv -----
// Shared restoring divider, one quotient bit per cycle, unsigned 64 by 64.
module eqbcg_div (
   input  logic                    clock,
   input  logic                    reset,
   input  eqbcg_pkg::div_req_type  div_req,
   output eqbcg_pkg::div_rsp_type  div_rsp
);
   localparam int DW = eqbcg_pkg::DW;

   logic          busy_ff, done_ff;
   logic [6:0]    cnt_ff;
   logic [DW:0]   rem_ff;
   logic [DW-1:0] quo_ff, den_ff;
   logic [DW:0]   rem_sh;
   logic          fits;

   always_comb begin
      rem_sh = {rem_ff[DW-1:0], quo_ff[DW-1]};
      fits   = (rem_sh >= {1'b0, den_ff});
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 7'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'(DW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.num;
         den_ff <= div_req.den;
      end else if (busy_ff) begin
         rem_ff <= fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         quo_ff <= {quo_ff[DW-2:0], fits};
      end
   end
endmodule

// ----- hdl/eqbcg_core.sv -----
// Back end: sequences the multiplier and divider through the cookbook formulas.
module eqbcg_core (
   input  logic                    clock,
   input  logic                    reset,
   input  eqbcg_pkg::job_if_type   job_in,
   output logic                    job_pop,
   output eqbcg_pkg::div_req_type  div_req,
   input  eqbcg_pkg::div_rsp_type  div_rsp,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output eqbcg_pkg::rsp_type      rsp_data
);
   localparam int VW = eqbcg_pkg::VW;
   localparam int MW = eqbcg_pkg::MW;
   localparam int PW = eqbcg_pkg::PW;
   localparam int DW = eqbcg_pkg::DW;
   localparam int QB = eqbcg_pkg::QB;
   localparam int CW = eqbcg_pkg::COEF_W;
   localparam int CF = eqbcg_pkg::COEF_FRAC_BITS;
   localparam int PB = eqbcg_pkg::POT_BITS;
   localparam int RS = eqbcg_pkg::RECIP_SH;

   eqbcg_pkg::state_type state_ff, state_in;
   eqbcg_pkg::band_type  band_ff;
   logic [eqbcg_pkg::POT_BITS-1:0] cut_ff;
   logic [MW-1:0]        y_ff, term_ff;
   logic [DW-1:0]        yacc_ff;
   logic [3:0]           k_ff;
   logic [eqbcg_pkg::CIDX_W-1:0] idx_ff;
   logic signed [VW-1:0] sum_ff, a_ff, ap_ff, am_ff, t_ff, amc_ff, apc_ff;
   logic signed [VW-1:0] b0_ff, b1_ff, b2_ff, a0_ff, a1_ff, a2_ff;
   logic signed [CW-1:0] coef_ff [0:eqbcg_pkg::NUM_COEF-1];
   logic [PW-1:0]        prod_ff;
   logic                 pneg_ff;
   logic                 rsp_valid_ff;
   eqbcg_pkg::rsp_type   rsp_data_ff;

   logic signed [VW-1:0] op_a, op_b, cw, al, qres, cx, ua;
   logic [PW-1:0]        rnd, rsh;
   logic [VW-1:0]        qmag;
   logic [MW-1:0]        kq;
   logic [DW-1:0]        cden, cq;
   logic                 out_load;
   logic signed [CW-1:0] csat;

   assign cw = eqbcg_pkg::band_cos(band_ff);
   assign al = eqbcg_pkg::band_alpha(band_ff);

   // series term divided by k through its reciprocal
   assign kq = MW'(prod_ff >> RS);

   // product rounded half away from zero back to Q30
   always_comb begin
      rnd  = prod_ff + eqbcg_pkg::QHALF;
      rsh  = rnd >> QB;
      qmag = rsh[VW-1:0];
      qres = pneg_ff ? -$signed(qmag) : $signed(qmag);
   end

   always_comb begin
      case (idx_ff)
         3'd0:    cx = b0_ff;
         3'd1:    cx = b1_ff;
         3'd2:    cx = b2_ff;
         3'd3:    cx = a1_ff;
         default: cx = a2_ff;
      endcase
      cden = (a0_ff > 0) ? DW'(a0_ff) : DW'(1);
      ua   = (a_ff > 0) ? a_ff : VW'(1);
      cq   = div_rsp.quot;
      if (cx[VW-1]) begin
         csat = (cq > DW'(64'h8000_0000)) ? eqbcg_pkg::COEF_MIN : -$signed(cq[CW-1:0]);
      end else begin
         csat = (cq > DW'(64'h7FFF_FFFF)) ? eqbcg_pkg::COEF_MAX : $signed(cq[CW-1:0]);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         eqbcg_pkg::S_IDLE:    if (job_in.valid) state_in = eqbcg_pkg::S_Y_MUL;
         eqbcg_pkg::S_Y_MUL:   state_in = eqbcg_pkg::S_Y_DIV;
         eqbcg_pkg::S_Y_DIV:   state_in = eqbcg_pkg::S_Y_WAIT;
         eqbcg_pkg::S_Y_WAIT:  if (yacc_ff[DW-1:PB] == '0) state_in = eqbcg_pkg::S_T_MUL;
         eqbcg_pkg::S_T_MUL:   state_in = eqbcg_pkg::S_T_DIV;
         eqbcg_pkg::S_T_DIV:   state_in = eqbcg_pkg::S_T_WAIT;
         eqbcg_pkg::S_T_WAIT: begin
            state_in = (k_ff == 4'(eqbcg_pkg::TAYLOR_TERMS)) ? eqbcg_pkg::S_A_MUL
                                                             : eqbcg_pkg::S_T_MUL;
         end
         eqbcg_pkg::S_A_MUL:   state_in = eqbcg_pkg::S_A_USE;
         eqbcg_pkg::S_A_USE: begin
            state_in = (band_ff == eqbcg_pkg::BAND_BYPASS) ? eqbcg_pkg::S_OUT
                                                           : eqbcg_pkg::S_T2_MUL;
         end
         eqbcg_pkg::S_T2_MUL:  state_in = eqbcg_pkg::S_T2_USE;
         eqbcg_pkg::S_T2_USE:  state_in = eqbcg_pkg::S_AMC_MUL;
         eqbcg_pkg::S_AMC_MUL: state_in = eqbcg_pkg::S_AMC_USE;
         eqbcg_pkg::S_AMC_USE: state_in = eqbcg_pkg::S_APC_MUL;
         eqbcg_pkg::S_APC_MUL: state_in = eqbcg_pkg::S_APC_USE;
         eqbcg_pkg::S_APC_USE: begin
            state_in = (band_ff == eqbcg_pkg::BAND_PEAK) ? eqbcg_pkg::S_AA_MUL
                                                         : eqbcg_pkg::S_B0_MUL;
         end
         eqbcg_pkg::S_B0_MUL:  state_in = eqbcg_pkg::S_B0_USE;
         eqbcg_pkg::S_B0_USE:  state_in = eqbcg_pkg::S_B1_MUL;
         eqbcg_pkg::S_B1_MUL:  state_in = eqbcg_pkg::S_B1_USE;
         eqbcg_pkg::S_B1_USE:  state_in = eqbcg_pkg::S_B2_MUL;
         eqbcg_pkg::S_B2_MUL:  state_in = eqbcg_pkg::S_B2_USE;
         eqbcg_pkg::S_B2_USE:  state_in = eqbcg_pkg::S_C_DIV;
         eqbcg_pkg::S_AA_MUL:  state_in = eqbcg_pkg::S_AA_USE;
         eqbcg_pkg::S_AA_USE:  state_in = eqbcg_pkg::S_ADIV_DIV;
         eqbcg_pkg::S_ADIV_DIV: state_in = eqbcg_pkg::S_ADIV_WAIT;
         eqbcg_pkg::S_ADIV_WAIT: if (div_rsp.done) state_in = eqbcg_pkg::S_C_DIV;
         eqbcg_pkg::S_C_DIV:   state_in = eqbcg_pkg::S_C_WAIT;
         eqbcg_pkg::S_C_WAIT: begin
            if (div_rsp.done) begin
               state_in = (idx_ff == 3'(eqbcg_pkg::NUM_COEF - 1)) ? eqbcg_pkg::S_OUT
                                                                  : eqbcg_pkg::S_C_DIV;
            end
         end
         eqbcg_pkg::S_OUT:     if (out_load) state_in = eqbcg_pkg::S_IDLE;
         default:              state_in = eqbcg_pkg::S_IDLE;
      endcase
   end

   // outputs: multiplier operands, divider requests, handshakes
   always_comb begin
      op_a        = '0;
      op_b        = '0;
      div_req     = '0;
      job_pop     = 1'b0;
      out_load    = 1'b0;
      case (state_ff)
         eqbcg_pkg::S_IDLE:    job_pop = job_in.valid;
         eqbcg_pkg::S_Y_MUL: begin
            op_a = VW'(cut_ff);
            op_b = VW'(eqbcg_pkg::EXP_RATE);
         end
         eqbcg_pkg::S_T_MUL: begin
            op_a = VW'(term_ff);
            op_b = VW'(y_ff);
         end
         eqbcg_pkg::S_T_DIV: begin
            op_a = VW'(qmag) + VW'(k_ff >> 1);
            op_b = eqbcg_pkg::recip_k(k_ff);
         end
         eqbcg_pkg::S_A_MUL: begin
            op_a = sum_ff;
            op_b = sum_ff;
         end
         eqbcg_pkg::S_T2_MUL: begin
            op_a = sum_ff;
            op_b = al;
         end
         eqbcg_pkg::S_AMC_MUL: begin
            op_a = am_ff;
            op_b = cw;
         end
         eqbcg_pkg::S_APC_MUL: begin
            op_a = ap_ff;
            op_b = cw;
         end
         eqbcg_pkg::S_B0_MUL: begin
            op_a = a_ff;
            op_b = (band_ff == eqbcg_pkg::BAND_LOW) ? (ap_ff - amc_ff + t_ff)
                                                    : (ap_ff + amc_ff + t_ff);
         end
         eqbcg_pkg::S_B1_MUL: begin
            op_a = a_ff;
            op_b = (band_ff == eqbcg_pkg::BAND_LOW) ? (am_ff - apc_ff) : (am_ff + apc_ff);
         end
         eqbcg_pkg::S_B2_MUL: begin
            op_a = a_ff;
            op_b = (band_ff == eqbcg_pkg::BAND_LOW) ? (ap_ff - amc_ff - t_ff)
                                                    : (ap_ff + amc_ff - t_ff);
         end
         eqbcg_pkg::S_AA_MUL: begin
            op_a = al;
            op_b = a_ff;
         end
         eqbcg_pkg::S_ADIV_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = (DW'(al) << QB) + (DW'(ua) >> 1);
            div_req.den   = DW'(ua);
         end
         eqbcg_pkg::S_C_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = (DW'(eqbcg_pkg::mag(cx)) << CF) + (cden >> 1);
            div_req.den   = cden;
         end
         eqbcg_pkg::S_OUT:     out_load = !rsp_valid_ff || !rsp_stall;
         default:              op_a = '0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= eqbcg_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      prod_ff <= PW'(eqbcg_pkg::mag(op_a)) * PW'(eqbcg_pkg::mag(op_b));
      pneg_ff <= op_a[VW-1] ^ op_b[VW-1];

      if (out_load) begin
         rsp_data_ff.coef_b0 <= coef_ff[0];
         rsp_data_ff.coef_b1 <= coef_ff[1];
         rsp_data_ff.coef_b2 <= coef_ff[2];
         rsp_data_ff.coef_a1 <= coef_ff[3];
         rsp_data_ff.coef_a2 <= coef_ff[4];
      end

      case (state_ff)
         eqbcg_pkg::S_IDLE: begin
            band_ff <= job_in.job.band;
            cut_ff  <= job_in.job.cut;
         end
         eqbcg_pkg::S_Y_DIV: begin
            yacc_ff <= prod_ff[DW-1:0] + eqbcg_pkg::POT_HALF;
            y_ff    <= '0;
         end
         eqbcg_pkg::S_Y_WAIT: begin
            // divide by 2^PB - 1: h*2^PB + l = h*(2^PB - 1) + (h + l)
            if (yacc_ff[DW-1:PB] != '0) begin
               y_ff    <= y_ff + MW'(yacc_ff >> PB);
               yacc_ff <= (yacc_ff >> PB) + DW'(yacc_ff[PB-1:0]);
            end else if (yacc_ff[PB-1:0] == eqbcg_pkg::POT_MAX) begin
               y_ff <= y_ff + MW'(1);
            end
            term_ff <= MW'(eqbcg_pkg::QONE);
            sum_ff  <= eqbcg_pkg::QONE;
            k_ff    <= 4'd1;
         end
         eqbcg_pkg::S_T_WAIT: begin
            term_ff <= kq;
            // alternating series for exp(-y)
            sum_ff  <= k_ff[0] ? sum_ff - VW'(kq) : sum_ff + VW'(kq);
            k_ff    <= k_ff + 4'd1;
         end
         eqbcg_pkg::S_A_USE: begin
            a_ff       <= qres;
            ap_ff      <= qres + eqbcg_pkg::QONE;
            am_ff      <= qres - eqbcg_pkg::QONE;
            coef_ff[0] <= CW'(64'd1 << CF);
            coef_ff[1] <= '0;
            coef_ff[2] <= '0;
            coef_ff[3] <= '0;
            coef_ff[4] <= '0;
            idx_ff     <= '0;
         end
         eqbcg_pkg::S_T2_USE:  t_ff   <= qres <<< 1;
         eqbcg_pkg::S_AMC_USE: amc_ff <= qres;
         eqbcg_pkg::S_APC_USE: apc_ff <= qres;
         eqbcg_pkg::S_B0_USE:  b0_ff  <= qres;
         eqbcg_pkg::S_B1_USE: begin
            b1_ff <= (band_ff == eqbcg_pkg::BAND_LOW) ? (qres <<< 1) : -(qres <<< 1);
         end
         eqbcg_pkg::S_B2_USE: begin
            b2_ff <= qres;
            if (band_ff == eqbcg_pkg::BAND_LOW) begin
               a0_ff <= ap_ff + amc_ff + t_ff;
               a1_ff <= -((am_ff + apc_ff) <<< 1);
               a2_ff <= ap_ff + amc_ff - t_ff;
            end else begin
               a0_ff <= ap_ff - amc_ff + t_ff;
               a1_ff <= (am_ff - apc_ff) <<< 1;
               a2_ff <= ap_ff - amc_ff - t_ff;
            end
         end
         eqbcg_pkg::S_AA_USE: begin
            b0_ff <= eqbcg_pkg::QONE + qres;
            b2_ff <= eqbcg_pkg::QONE - qres;
            b1_ff <= -(cw <<< 1);
            a1_ff <= -(cw <<< 1);
         end
         eqbcg_pkg::S_ADIV_WAIT: begin
            if (div_rsp.done) begin
               a0_ff <= eqbcg_pkg::QONE + VW'(div_rsp.quot[MW-1:0]);
               a2_ff <= eqbcg_pkg::QONE - VW'(div_rsp.quot[MW-1:0]);
            end
         end
         eqbcg_pkg::S_C_WAIT: begin
            if (div_rsp.done) begin
               coef_ff[idx_ff] <= csat;
               idx_ff          <= idx_ff + 3'd1;
            end
         end
         default: ;
      endcase
   end
endmodule

// ----- tb/eq_biquad_coefficient_generator_unit_test.sv -----
// Self-checking testbench for the EQ biquad coefficient generator: directed and random bands/pots.
module eq_biquad_coefficient_generator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int              CW       = eqbcg_pkg::COEF_W;
   localparam int              CF       = eqbcg_pkg::COEF_FRAC_BITS;
   localparam int              PTW      = eqbcg_pkg::POT_W;
   localparam longint unsigned Q_HALF   = 64'd1 << 29;
   localparam longint          Q_ONE    = 64'sd1 << 30;
   localparam longint unsigned POT_FULL = (64'd1 << eqbcg_pkg::POT_BITS) - 1;
   localparam longint unsigned GAIN_K   = 64'd463571610;
   localparam int              NUM_RANDOM = 1750;

   class coef_scoreboard;
      eqbcg_pkg::rsp_type coef_sets_due[$];
      int      errors = 0;

      // Q30 product, rounded half away from zero
      function automatic longint q30_mul(longint a, longint b);
         longint unsigned ua, ub, p;
         bit neg;
         neg = (a < 0) != (b < 0);
         ua = (a < 0) ? -a : a;
         ub = (b < 0) ? -b : b;
         p = (ua * ub + Q_HALF) >> 30;
         return neg ? -longint'(p) : longint'(p);
      endfunction

      function automatic logic signed [CW-1:0] to_q4_28(longint num, longint den);
         longint unsigned ud, un, q;
         bit neg;
         ud = (den > 0) ? den : 64'd1;
         neg = num < 0;
         un = neg ? -num : num;
         q = ((un << CF) + ud / 2) / ud;
         if (neg)
            return (q > 64'd2147483648) ? eqbcg_pkg::COEF_MIN : CW'(-longint'(q));
         else
            return (q > 64'd2147483647) ? eqbcg_pkg::COEF_MAX : CW'(q);
      endfunction

      // sqrt(A) = exp(-y) by Taylor series
      function automatic longint sqrt_gain(logic [PTW-1:0] pot);
         longint unsigned p, y, term;
         longint sum;
         p = (pot > POT_FULL) ? POT_FULL : pot;
         y = ((POT_FULL - p) * GAIN_K + POT_FULL / 2) / POT_FULL;
         term = Q_ONE;
         sum = Q_ONE;
         for (int k = 1; k <= eqbcg_pkg::TAYLOR_TERMS; k++) begin
            term = (term * y + Q_HALF) >> 30;
            term = (term + longint'(k / 2)) / longint'(k);
            if (k % 2) sum -= longint'(term);
            else sum += longint'(term);
         end
         return sum;
      endfunction

      function automatic eqbcg_pkg::rsp_type biquad_coefs(eqbcg_pkg::req_type r);
         eqbcg_pkg::rsp_type c;
         eqbcg_pkg::band_type band;
         longint s, a, ap, am, cw, al, t, amc, apc, aa, adiv;
         longint b0, b1, b2, a0, a1, a2;
         longint unsigned ua;
         band = eqbcg_pkg::band_type'(r.action);
         if (band == eqbcg_pkg::BAND_BYPASS) begin
            c.coef_b0 = CW'(64'd1 << CF);
            c.coef_b1 = '0;
            c.coef_b2 = '0;
            c.coef_a1 = '0;
            c.coef_a2 = '0;
            return c;
         end
         s = sqrt_gain(r.pot_level);
         a = q30_mul(s, s);
         ap = a + Q_ONE;
         am = a - Q_ONE;
         case (band)
            eqbcg_pkg::BAND_LOW: begin
               cw = eqbcg_pkg::COS_400;
               al = eqbcg_pkg::ALPHA_400;
            end
            eqbcg_pkg::BAND_PEAK: begin
               cw = eqbcg_pkg::COS_1K;
               al = eqbcg_pkg::ALPHA_1K;
            end
            default: begin
               cw = eqbcg_pkg::COS_2K;
               al = eqbcg_pkg::ALPHA_2K;
            end
         endcase
         t = 2 * q30_mul(s, al);
         amc = q30_mul(am, cw);
         apc = q30_mul(ap, cw);
         case (band)
            eqbcg_pkg::BAND_LOW: begin
               b0 = q30_mul(a, ap - amc + t);
               b1 = 2 * q30_mul(a, am - apc);
               b2 = q30_mul(a, ap - amc - t);
               a0 = ap + amc + t;
               a1 = -2 * (am + apc);
               a2 = ap + amc - t;
            end
            eqbcg_pkg::BAND_HIGH: begin
               b0 = q30_mul(a, ap + amc + t);
               b1 = -2 * q30_mul(a, am + apc);
               b2 = q30_mul(a, ap + amc - t);
               a0 = ap - amc + t;
               a1 = 2 * (am - apc);
               a2 = ap - amc - t;
            end
            default: begin
               aa = q30_mul(al, a);
               ua = (a > 0) ? a : 64'd1;
               adiv = longint'(((longint'(al) << 30) + ua / 2) / ua);
               b0 = Q_ONE + aa;
               b1 = -2 * cw;
               b2 = Q_ONE - aa;
               a0 = Q_ONE + adiv;
               a1 = -2 * cw;
               a2 = Q_ONE - adiv;
            end
         endcase
         c.coef_b0 = to_q4_28(b0, a0);
         c.coef_b1 = to_q4_28(b1, a0);
         c.coef_b2 = to_q4_28(b2, a0);
         c.coef_a1 = to_q4_28(a1, a0);
         c.coef_a2 = to_q4_28(a2, a0);
         return c;
      endfunction

      function void note_request(eqbcg_pkg::req_type r);
         coef_sets_due.push_back(biquad_coefs(r));
      endfunction

      function void check_coefs(eqbcg_pkg::rsp_type got);
         eqbcg_pkg::rsp_type want;
         if (coef_sets_due.size() == 0) begin
            $error("unexpected coefficient set b0=%0d", got.coef_b0);
            errors++;
            return;
         end
         want = coef_sets_due.pop_front();
         if (got.coef_b0 !== want.coef_b0) begin
            $error("coef_b0: expected %0d actual %0d", want.coef_b0, got.coef_b0);
            errors++;
         end
         if (got.coef_b1 !== want.coef_b1) begin
            $error("coef_b1: expected %0d actual %0d", want.coef_b1, got.coef_b1);
            errors++;
         end
         if (got.coef_b2 !== want.coef_b2) begin
            $error("coef_b2: expected %0d actual %0d", want.coef_b2, got.coef_b2);
            errors++;
         end
         if (got.coef_a1 !== want.coef_a1) begin
            $error("coef_a1: expected %0d actual %0d", want.coef_a1, got.coef_a1);
            errors++;
         end
         if (got.coef_a2 !== want.coef_a2) begin
            $error("coef_a2: expected %0d actual %0d", want.coef_a2, got.coef_a2);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   eqbcg_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   eqbcg_pkg::rsp_type rsp_data;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit presenting = 1'b0;

   eqbcg_pkg::band_type band_list[4] = '{eqbcg_pkg::BAND_LOW, eqbcg_pkg::BAND_PEAK,
                                         eqbcg_pkg::BAND_HIGH, eqbcg_pkg::BAND_BYPASS};

   coef_scoreboard coef_sb = new();

   eq_biquad_coefficient_generator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) coef_sb.check_coefs(rsp_data);
      rsp_stall <= (rsp_stall_pct > 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   // valid stays high across back-to-back transactions
   task automatic send_request(input eqbcg_pkg::band_type band,
                               input logic [PTW-1:0] pot);
      eqbcg_pkg::req_type r;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      r.action = band;
      r.pot_level = pot;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      coef_sb.note_request(r);
   endtask

   task automatic send_random;
      int pick;
      eqbcg_pkg::band_type band;
      logic [PTW-1:0] pot;
      pick = $urandom_range(9);
      band = (pick == 9) ? eqbcg_pkg::BAND_BYPASS : eqbcg_pkg::band_type'(pick % 3);
      case ($urandom_range(7))
         0: pot = '0;
         1: pot = eqbcg_pkg::POT_MAX;
         default: pot = PTW'($urandom);
      endcase
      send_request(band, pot);
   endtask

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (band_list[i]) begin
         send_request(band_list[i], '0);
         send_request(band_list[i], 12'd1);
         send_request(band_list[i], 12'h800);
         send_request(band_list[i], 12'hAAA);
         send_request(band_list[i], eqbcg_pkg::POT_MAX - 1);
         send_request(band_list[i], eqbcg_pkg::POT_MAX);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 56; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 56; end
            default: begin send_idle_pct = 32; rsp_stall_pct = 32; end
         endcase
         for (int n = 0; n < NUM_RANDOM / 4; n++) send_random();
      end
      req_valid <= 1'b0;

      waited = 0;
      while (coef_sb.coef_sets_due.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (1400) @(posedge clock);
      if (coef_sb.errors == 0 && coef_sb.coef_sets_due.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #(64'd60_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
